[rtl/scfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfd_pkg
// Shared types and constants of the self-calibrating fire detector: beat
// payloads, configuration register indexes, reset values and state widths.
// ----------------------------------------------------------------------------
package scfd_pkg;

	localparam int TEMP_W   = 14;
	localparam int LIGHT_W  = 12;
	localparam int TLIM_W   = 15;
	localparam int LLIM_W   = 13;
	localparam int TSUM_W   = 20;
	localparam int LSUM_W   = 18;
	localparam int CNT_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_index_t;

	localparam cfg_index_t CFG_RECAL_PERIOD = 2'd0;
	localparam cfg_index_t CFG_TEMP_MARGIN  = 2'd1;

	localparam logic [CNT_W-1:0]  RECAL_PERIOD_RST = 16'd3600;
	localparam logic [TEMP_W-1:0] TEMP_MARGIN_RST  = 14'd2000;

	typedef struct packed {
		logic [TEMP_W-1:0]  temp_sample;
		logic [LIGHT_W-1:0] light_sample;
	} sample_t;

	typedef struct packed {
		logic              fire;
		logic              calibrating;
		logic [TLIM_W-1:0] temp_limit;
		logic [LLIM_W-1:0] light_limit;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0]  recal_period;
		logic [TEMP_W-1:0] temp_margin;
	} cfg_t;

endpackage

[rtl/scfd_cdiv.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfd_cdiv
// Unsigned division by a constant, done as a multiplication by a rounded-up
// reciprocal and a shift. The quotient is exact for every input value.
// ----------------------------------------------------------------------------
module scfd_cdiv #(
	parameter int W       = 20,
	parameter int DIVISOR = 10
) (
	input  logic [W-1:0] num,
	output logic [W-1:0] quo
);

	localparam int SH = W + $clog2(DIVISOR);
	localparam int PW = SH + W;
	localparam logic [PW-1:0] RECIP =
		PW'(((longint'(1) << SH) + longint'(DIVISOR) - 1) / longint'(DIVISOR));

	logic [PW-1:0] prod;

	assign prod = PW'(num) * RECIP;
	assign quo  = prod[SH +: W];

endmodule

[rtl/scfd_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfd_cfg
// Configuration register file: recalibration period and temperature margin.
// Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module scfd_cfg
	import scfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  cfg_index_t           cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.recal_period <= RECAL_PERIOD_RST;
			cfg_q.temp_margin  <= TEMP_MARGIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RECAL_PERIOD: cfg_q.recal_period <= cfg_data[CNT_W-1:0];
				CFG_TEMP_MARGIN:  cfg_q.temp_margin  <= cfg_data[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

[rtl/scfd_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfd_engine
// Detector state and the combinational work for one tick: calibration sums,
// threshold update through constant dividers, alarm check and period count.
// ----------------------------------------------------------------------------
module scfd_engine
	import scfd_pkg::*;
#(
	parameter int CAL_SAMPLES = 10
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  sample_t item,
	input  cfg_t    cfg,
	output result_t result
);

	localparam int CIW = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;
	localparam logic [CIW-1:0] LAST_IDX = CIW'(CAL_SAMPLES - 1);

	logic               in_cal_q;
	logic [CIW-1:0]     cal_index_q;
	logic [TSUM_W-1:0]  temp_sum_q;
	logic [LSUM_W-1:0]  light_sum_q;
	logic [CNT_W-1:0]   check_count_q;
	logic [TLIM_W-1:0]  temp_thr_q;
	logic [LLIM_W-1:0]  light_thr_q;
	logic               alarm_q;

	logic               in_cal_d;
	logic [CIW-1:0]     cal_index_d;
	logic [TSUM_W-1:0]  temp_sum_d;
	logic [LSUM_W-1:0]  light_sum_d;
	logic [CNT_W-1:0]   check_count_d;
	logic [TLIM_W-1:0]  temp_thr_d;
	logic [LLIM_W-1:0]  light_thr_d;
	logic               alarm_d;

	logic [TSUM_W-1:0]  temp_acc;
	logic [LSUM_W-1:0]  light_acc;
	logic [TSUM_W-1:0]  temp_avg;
	logic [LSUM_W-1:0]  light_avg;
	logic [CNT_W-1:0]   count_inc;
	logic               last_cal;

	assign temp_acc  = temp_sum_q + TSUM_W'(item.temp_sample);
	assign light_acc = light_sum_q + LSUM_W'(item.light_sample);
	assign count_inc = check_count_q + CNT_W'(1);
	assign last_cal  = (cal_index_q == LAST_IDX);

	scfd_cdiv #(
		.W       (TSUM_W),
		.DIVISOR (CAL_SAMPLES)
	) u_temp_div (
		.num (temp_acc),
		.quo (temp_avg)
	);

	scfd_cdiv #(
		.W       (LSUM_W),
		.DIVISOR (CAL_SAMPLES)
	) u_light_div (
		.num (light_acc),
		.quo (light_avg)
	);

	always_comb begin
		in_cal_d      = in_cal_q;
		cal_index_d   = cal_index_q;
		temp_sum_d    = temp_sum_q;
		light_sum_d   = light_sum_q;
		check_count_d = check_count_q;
		temp_thr_d    = temp_thr_q;
		light_thr_d   = light_thr_q;
		alarm_d       = alarm_q;
		if (in_cal_q) begin
			temp_sum_d  = temp_acc;
			light_sum_d = light_acc;
			if (last_cal) begin
				// Half of the light average equals the sum over twice the sample count.
				temp_thr_d    = TLIM_W'(temp_avg) + TLIM_W'(cfg.temp_margin);
				light_thr_d   = LLIM_W'(light_avg) + LLIM_W'(light_avg >> 1);
				in_cal_d      = 1'b0;
				cal_index_d   = '0;
				check_count_d = '0;
			end else begin
				cal_index_d = cal_index_q + CIW'(1);
			end
		end else begin
			alarm_d = (TLIM_W'(item.temp_sample) >= temp_thr_q) &&
				(LLIM_W'(item.light_sample) >= light_thr_q);
			check_count_d = count_inc;
			if (count_inc >= cfg.recal_period) begin
				in_cal_d    = 1'b1;
				cal_index_d = '0;
				temp_sum_d  = '0;
				light_sum_d = '0;
			end
		end
	end

	assign result.fire        = alarm_d;
	assign result.calibrating = in_cal_q;
	assign result.temp_limit  = temp_thr_d;
	assign result.light_limit = light_thr_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cal_q      <= 1'b1;
			cal_index_q   <= '0;
			temp_sum_q    <= '0;
			light_sum_q   <= '0;
			check_count_q <= '0;
			temp_thr_q    <= '0;
			light_thr_q   <= '0;
			alarm_q       <= 1'b0;
		end else if (step) begin
			in_cal_q      <= in_cal_d;
			cal_index_q   <= cal_index_d;
			temp_sum_q    <= temp_sum_d;
			light_sum_q   <= light_sum_d;
			check_count_q <= check_count_d;
			temp_thr_q    <= temp_thr_d;
			light_thr_q   <= light_thr_d;
			alarm_q       <= alarm_d;
		end
	end

	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		!in_cal_q |-> cal_index_q == '0)
		else $error("calibration index is nonzero outside calibration");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_index_q <= LAST_IDX)
		else $error("calibration index ran past the last sample");

	a_cal_exit: assert property (@(posedge clk) disable iff (!arst_n)
		step && in_cal_q && last_cal |=> !in_cal_q && check_count_q == '0)
		else $error("calibration round did not end on its last sample");

	a_alarm_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step && in_cal_q |=> $stable(alarm_q))
		else $error("alarm changed during a calibration tick");

endmodule

[rtl/self_calibrating_fire_detector_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// self_calibrating_fire_detector_core
// Fire detector that calibrates its temperature and light thresholds from
// the mean of a run of samples and then raises an alarm when both readings
// reach their thresholds.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake              | Payload
//  sample   | in        | sample_valid / stall   | sample_t: temperature, light
//  result   | out       | result_valid / stall   | result_t: alarm, calibrating, limits
//  cfg      | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One beat is taken per cycle while the result side does not stall; its
// result passes the sample register and then the result register before it
// is offered. The sample register feeds one combinational pass (sum, constant
// divide by reciprocal multiply, add) into the result register.
// After reset the first CAL_SAMPLES beats are calibration ticks, thresholds
// read zero until then, and the configuration registers hold their defaults.
// A stalled result register still lets one more sample beat in.
// ----------------------------------------------------------------------------
module self_calibrating_fire_detector_core
	import scfd_pkg::*;
#(
	parameter int CAL_SAMPLES = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  sample_t              sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  cfg_index_t           cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	cfg_t    cfg;
	sample_t item_s1;
	logic    valid_s1;
	result_t result_q;
	logic    result_valid_q;
	result_t result_d;
	logic    advance;
	logic    accept;

	assign advance      = valid_s1 && (!result_valid_q || !result_stall);
	assign sample_stall = valid_s1 && !advance;
	assign accept       = sample_valid && !sample_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	scfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	scfd_engine #(
		.CAL_SAMPLES (CAL_SAMPLES)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= sample;
		end
		if (advance) begin
			result_q <= result_d;
		end
	end

endmodule
